FILE: rtl/nge_pkg.sv
// ---------------------------------------------------------------------------
// nge_pkg: shared types for the next greater element finder
// Sequencer states and the shift control that drives the stack cell chain.
// ---------------------------------------------------------------------------
package nge_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_OVF,
      S_POP,
      S_FLUSH
   } state_type;

   // shift control broadcast to every cell of the chain
   typedef struct packed {
      logic push;   // every entry moves one cell deeper, new entry at the top
      logic pop;    // every entry moves one cell toward the top
   } shift_ctl_type;

   // width of the position field on the result beat
   localparam int POS_OUT_W = 5;
   // width of the value field on both channels
   localparam int DATA_W = 32;

endpackage

FILE: rtl/nge_cell.sv
// ---------------------------------------------------------------------------
// nge_cell: one entry of the shifting stack
// Holds a valid bit, a value and a position; takes the entry from the cell
// above on push and from the cell below on pop.
// ---------------------------------------------------------------------------
module nge_cell
   import nge_pkg::*;
#(
   parameter int VW = 32,
   parameter int PW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  shift_ctl_type        ctl,
   input  logic                 up_valid,
   input  logic signed [VW-1:0] up_value,
   input  logic [PW-1:0]        up_pos,
   input  logic                 dn_valid,
   input  logic signed [VW-1:0] dn_value,
   input  logic [PW-1:0]        dn_pos,
   output logic                 valid,
   output logic signed [VW-1:0] value,
   output logic [PW-1:0]        pos
);

   logic                 valid_ff, valid_in;
   logic signed [VW-1:0] value_ff, value_in;
   logic [PW-1:0]        pos_ff, pos_in;

   // neighbor select
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctl.push) begin
         valid_in = up_valid;
         value_in = up_value;
         pos_in   = up_pos;
      end else if (ctl.pop) begin
         valid_in = dn_valid;
         value_in = dn_value;
         pos_in   = dn_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign pos   = pos_ff;

endmodule

FILE: rtl/next_greater_element_finder.sv
// ---------------------------------------------------------------------------
// next_greater_element_finder: next greater element over a stream
// Monotonic non-increasing stack held in a chain of shifting cells.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one signed element per beat, req_tlast on the final one.
//   rsp_* returns results: position and next greater value in tdata,
//   found / overflow in tuser, tlast on the last result of an input beat.
//   An element pops every waiting entry with a smaller value (one result
//   each, top first), then is pushed. On the final element the remaining
//   entries are flushed with found=0 and the sequence restarts at 0.
//   Elements past MAX_LEN give one overflow result and are dropped.
// Timing:
//   The beat is taken in S_IDLE; S_POP then pops each smaller entry with
//   one result and pushes the element, and S_FLUSH pops each waiting entry.
//   A new element is taken only back in S_IDLE. The stack top is one
//   compare per cycle while rsp_tready does not stall. A result is registered
//   and shows in the cycle after it is made; a stalled rsp_tready holds the sequencer.
//   Reset empties the stack and clears the element count.
// ---------------------------------------------------------------------------
module next_greater_element_finder
   import nge_pkg::*;
#(
   parameter int MAX_LEN     = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] position, [36:5] next_greater, zero pad
   output logic [1:0]  rsp_tuser,   // [0] found, [1] overflow
   output logic        rsp_tlast    // end_of_run
);

   localparam int VW = VALUE_WIDTH;
   localparam int PW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   state_type state_ff, state_in;
   shift_ctl_type ctl;

   logic                 hold_last_ff, hold_last_in;
   logic signed [VW-1:0] hold_v_ff, hold_v_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 count_inc, count_clr;

   logic                 cell_valid [MAX_LEN];
   logic signed [VW-1:0] cell_value [MAX_LEN];
   logic [PW-1:0]        cell_pos   [MAX_LEN];

   logic                 rsp_valid_ff;
   logic [POS_OUT_W-1:0] rsp_pos_ff, e_pos;
   logic [DATA_W-1:0]    rsp_val_ff, e_val;
   logic                 rsp_found_ff, e_found;
   logic                 rsp_ovf_ff, e_ovf;
   logic                 rsp_end_ff, e_end;
   logic                 emit;

   logic                 accept, out_free, full, top_lt, next_lt;
   logic signed [63:0]   in_ext, out_ext;
   logic [PW+POS_OUT_W-1:0] pos_ext;

   // input value to the compare width, compare width back to the port
   assign in_ext  = 64'(signed'(req_tdata));
   assign out_ext = 64'(hold_v_ff);
   assign pos_ext = {{POS_OUT_W{1'b0}}, cell_pos[0]};

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (count_ff == CW'(MAX_LEN));
   assign top_lt   = cell_valid[0] && (cell_value[0] < hold_v_ff);
   assign next_lt  = cell_valid[1] && (cell_value[1] < hold_v_ff);

   // stack cell chain, cell 0 is the top
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic                 up_v, dn_v;
      logic signed [VW-1:0] up_d, dn_d;
      logic [PW-1:0]        up_p, dn_p;
      if (i == 0) begin : g_top
         assign up_v = 1'b1;
         assign up_d = hold_v_ff;
         assign up_p = count_ff[PW-1:0];
      end else begin : g_mid
         assign up_v = cell_valid[i-1];
         assign up_d = cell_value[i-1];
         assign up_p = cell_pos[i-1];
      end
      if (i == MAX_LEN - 1) begin : g_bot
         assign dn_v = 1'b0;
         assign dn_d = '0;
         assign dn_p = '0;
      end else begin : g_nbot
         assign dn_v = cell_valid[i+1];
         assign dn_d = cell_value[i+1];
         assign dn_p = cell_pos[i+1];
      end
      nge_cell #(.VW(VW), .PW(PW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .up_valid (up_v),
         .up_value (up_d),
         .up_pos   (up_p),
         .dn_valid (dn_v),
         .dn_value (dn_d),
         .dn_pos   (dn_p),
         .valid    (cell_valid[i]),
         .value    (cell_value[i]),
         .pos      (cell_pos[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = full ? S_OVF : S_POP;
         end
         S_OVF: begin
            if (out_free) state_in = (hold_last_ff && cell_valid[0]) ? S_FLUSH : S_IDLE;
         end
         S_POP: begin
            if (!top_lt) state_in = hold_last_ff ? S_FLUSH : S_IDLE;
         end
         S_FLUSH: begin
            if (out_free && !cell_valid[1]) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      ctl        = '0;
      count_inc  = 1'b0;
      count_clr  = 1'b0;
      emit       = 1'b0;
      e_pos      = '0;
      e_val      = '0;
      e_found    = 1'b0;
      e_ovf      = 1'b0;
      e_end      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_OVF: begin
            if (out_free) begin
               emit  = 1'b1;
               e_ovf = 1'b1;
               e_end = !(hold_last_ff && cell_valid[0]);
               count_clr = hold_last_ff && !cell_valid[0];
            end
         end
         S_POP: begin
            if (top_lt) begin
               if (out_free) begin
                  emit    = 1'b1;
                  e_pos   = pos_ext[POS_OUT_W-1:0];
                  e_val   = out_ext[DATA_W-1:0];
                  e_found = 1'b1;
                  e_end   = !hold_last_ff && !next_lt;
                  ctl.pop = 1'b1;
               end
            end else begin
               ctl.push  = 1'b1;
               count_inc = 1'b1;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               emit      = 1'b1;
               e_pos     = pos_ext[POS_OUT_W-1:0];
               e_end     = !cell_valid[1];
               ctl.pop   = 1'b1;
               count_clr = !cell_valid[1];
            end
         end
         default: ;
      endcase
   end

   // held item and element count
   always_comb begin
      hold_v_in    = hold_v_ff;
      hold_last_in = hold_last_ff;
      if (accept) begin
         hold_v_in    = in_ext[VW-1:0];
         hold_last_in = req_tlast;
      end
      count_in = count_ff;
      if (count_clr)      count_in = '0;
      else if (count_inc) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (emit)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_v_ff    <= hold_v_in;
      hold_last_ff <= hold_last_in;
      if (emit) begin
         rsp_pos_ff   <= e_pos;
         rsp_val_ff   <= e_val;
         rsp_found_ff <= e_found;
         rsp_ovf_ff   <= e_ovf;
         rsp_end_ff   <= e_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_val_ff, rsp_pos_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_end_ff;

`ifndef SYNTHESIS
   // shift directions are exclusive
   a_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("push and pop in the same cycle");

   // stack stays packed toward the top
   a_packed: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> cell_valid[0])
      else $error("hole at the top of the stack");

   // end of flush leaves an empty stack and a cleared count
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free && !cell_valid[1])
      |=> (count_ff == '0 && !cell_valid[0] && state_ff == S_IDLE))
      else $error("flush did not restart the sequence");

   // pushes only happen below the length limit
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !full)
      else $error("push with the sequence full");
`endif

endmodule

FILE: dv/next_greater_element_finder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// next_greater_element_finder_test: stream test of the next greater finder
// Table-driven directed beats, then random sequences checked against a
// behavioral stack model. Bursty sender, patterned receiver stalls, and
// one long receiver hold-off to back the block up.
// ---------------------------------------------------------------------------
module next_greater_element_finder_test;
   import nge_pkg::*;

   localparam int MAX_LEN   = 32;
   localparam int IDLE_LIM  = 20000;

   typedef struct packed {
      logic [4:0]  position;
      logic [31:0] next_greater;
      logic        found;
      logic        overflow;
      logic        end_of_run;
   } answer_t;

   typedef struct {
      logic [31:0] value;
      logic        last_in;
      bit          typed;     // expected results typed in below
      int          n_typed;
      answer_t     typed_ans [2];
   } stim_row_t;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   next_greater_element_finder DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // predictor state
   logic signed [31:0] pend_val [MAX_LEN];
   logic [4:0]         pend_pos [MAX_LEN];
   int                 pend_depth;
   int                 seq_count;
   answer_t            answers_due [$];
   int                 errors;
   bit                 hold_off;
   int                 idle_cycles;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic answer_t mk(logic [4:0] p, logic [31:0] v, logic f, logic o, logic e);
      answer_t a;
      a.position = p; a.next_greater = v; a.found = f; a.overflow = o; a.end_of_run = e;
      return a;
   endfunction

   // next greater element update for one accepted beat
   task automatic predict_answers(logic signed [31:0] v, logic lst);
      int first;
      first = answers_due.size();
      if (seq_count >= MAX_LEN) begin
         answers_due.push_back(mk(0, 0, 0, 1, 0));
      end else begin
         while (pend_depth > 0 && pend_val[pend_depth-1] < v) begin
            pend_depth--;
            answers_due.push_back(mk(pend_pos[pend_depth], v, 1, 0, 0));
         end
         pend_val[pend_depth] = v;
         pend_pos[pend_depth] = seq_count[4:0];
         pend_depth++;
         seq_count++;
      end
      if (lst) begin
         while (pend_depth > 0) begin
            pend_depth--;
            answers_due.push_back(mk(pend_pos[pend_depth], 0, 0, 0, 0));
         end
         seq_count = 0;
      end
      if (answers_due.size() > first)
         answers_due[answers_due.size()-1].end_of_run = 1;
   endtask

   // result checker
   always @(posedge clock) begin
      answer_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk(rsp_tdata[4:0], rsp_tdata[36:5], rsp_tuser[0], rsp_tuser[1], rsp_tlast);
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %h", $time, got);
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
            end
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   initial begin
      int phase;
      rsp_tready = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_tready <= 0;
         else if (phase % 64 < 20) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIM) begin
            $display("next_greater_element_finder_test failed");
            $finish;
         end
      end
   end

   int burst_left;

   // offer one beat, wait for acceptance, predict
   task automatic send_beat(logic [31:0] v, logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1;
      req_tdata  <= v;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_answers(v, lst);
      burst_left--;
   endtask

   function automatic logic [31:0] rand_value(int mode);
      case (mode)
         0: return $urandom_range(0, 7) - 4;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom();
      endcase
   endfunction

   stim_row_t rows [$];

   task automatic add_row(logic [31:0] v, logic l);
      stim_row_t r;
      r.value = v; r.last_in = l; r.typed = 0; r.n_typed = 0;
      rows.push_back(r);
   endtask

   initial begin
      int len, mode, exp_base;
      bit held;
      stim_row_t r;
      errors = 0; hold_off = 0; burst_left = 0; held = 0;
      pend_depth = 0; seq_count = 0;
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table; single-element sequences after reset read off directly
      r.value = 32'h80000000; r.last_in = 1; r.typed = 1; r.n_typed = 1;
      r.typed_ans[0] = mk(0, 0, 0, 0, 1);
      rows.push_back(r);
      r.value = 32'h7fffffff; rows.push_back(r);
      add_row(32'h80000000, 0);   // min then max pops it
      add_row(32'h7fffffff, 0);
      add_row(32'h7fffffff, 0);   // equal does not pop
      add_row(32'hffffffff, 0);   // no result
      add_row(32'h00000000, 0);
      add_row(32'h00000005, 0);
      add_row(32'h00000003, 1);   // flush top down
      foreach (rows[i]) begin
         send_beat(rows[i].value, rows[i].last_in);
         // new answers sit at the tail of the queue
         exp_base = answers_due.size() - rows[i].n_typed;
         if (rows[i].typed)
            for (int k = 0; k < rows[i].n_typed; k++)
               if (answers_due[exp_base+k] !== rows[i].typed_ans[k]) begin
                  errors++;
                  $display("%0t: table row %0d expected %h actual %h", $time, i,
                     rows[i].typed_ans[k], answers_due[exp_base+k]);
               end
      end
      // overflow: 34 descending elements, the two extras overflow, the final one carries last
      for (int i = 0; i < 34; i++)
         send_beat(32'd100 - i, i == 33);

      // random sequences
      for (int n = 0; n < 390; ) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
         mode = $urandom_range(0, 3);
         if (!held && n > 150) begin
            held = 1;
            fork
               begin hold_off = 1; repeat (300) @(posedge clock); hold_off = 0; end
            join_none
         end
         for (int i = 0; i < len; i++)
            send_beat(rand_value(mode), i == len - 1);
         n += len;
      end
      req_tvalid <= 0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && answers_due.size() == 0)
         $display("next_greater_element_finder_test passed");
      else
         $display("next_greater_element_finder_test failed");
      $finish;
   end
endmodule
